[hdl/tcs_pkg.sv]
// Shared types and constants for the texture color sampler.
package tcs_pkg;

  localparam int COORD_W    = 32;
  localparam int CELL_W     = 31;
  localparam int COLOR_W    = 24;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int STORE_AW   = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  // Checker divider: one quotient bit per stage, final parity lands at index DIV_LAST
  localparam int DIV_LAST   = 31;
  // Image read data is registered at this pipeline index
  localparam int MEM_STAGE  = 4;
  localparam int TEX_DLY    = DIV_LAST - MEM_STAGE;
  localparam int NUM_AXES   = 3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef enum logic [1:0] {
    MODE_SOLID   = 2'd0,
    MODE_CHECKER = 2'd1,
    MODE_PLANAR  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_CELL_SIZE  = 3'd1,
    CFG_COLOR_A    = 3'd2,
    CFG_COLOR_B    = 3'd3,
    CFG_PLANE_S_XY = 3'd4,
    CFG_PLANE_S_ZW = 3'd5,
    CFG_PLANE_R_XY = 3'd6,
    CFG_PLANE_R_ZW = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] s_xy;
    logic [CFG_W-1:0] s_zw;
    logic [CFG_W-1:0] r_xy;
    logic [CFG_W-1:0] r_zw;
  } plane_cfg_t;

  // One image store access: write when we, else read
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [COLOR_W-1:0]  data;
  } mem_req_t;

endpackage

[hdl/tcs_if.sv]
// Channel interfaces for sample/write transactions and result transactions.
interface tcs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [tcs_pkg::COORD_W-1:0]  point_x;
  logic signed [tcs_pkg::COORD_W-1:0]  point_y;
  logic signed [tcs_pkg::COORD_W-1:0]  point_z;
  logic [7:0]                          texel_row;
  logic [7:0]                          texel_col;
  logic [tcs_pkg::COLOR_W-1:0]         texel_color;

  modport source (output valid, opcode, point_x, point_y, point_z, texel_row, texel_col,
                  texel_color, input ready);
  modport sink (input valid, opcode, point_x, point_y, point_z, texel_row, texel_col,
                texel_color, output ready);
endinterface

interface tcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcs_pkg::COLOR_W-1:0] sampled_color;

  modport source (output valid, sampled_color, input ready);
  modport sink (input valid, sampled_color, output ready);
endinterface

[hdl/tcs_chk_div.sv]
// Pipelined restoring divider that yields the checker cell parity.
module tcs_chk_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [tcs_pkg::COORD_W-1:0] px,
  input  logic signed [tcs_pkg::COORD_W-1:0] py,
  input  logic signed [tcs_pkg::COORD_W-1:0] pz,
  input  logic [tcs_pkg::CELL_W-1:0]         cell_sz,
  output logic                               parity
);

  localparam int NA = tcs_pkg::NUM_AXES;
  localparam int NS = tcs_pkg::DIV_LAST;
  localparam int W  = tcs_pkg::CELL_W;

  logic [W-1:0] dvd_r [NS][NA];
  logic [W-1:0] rem_r [NS][NA];
  logic [W-1:0] cs_r  [NS];
  logic         flip_r[NS];
  logic         qlsb_r[NA];
  logic         flip_last_r;

  logic signed [tcs_pkg::COORD_W-1:0] pin [NA];
  logic [W:0]   trial [NS+1][NA];
  logic         qbit  [NS+1][NA];
  logic [W-1:0] rnext [NS+1][NA];

  assign pin[0] = px;
  assign pin[1] = py;
  assign pin[2] = pz;

  // Compare-subtract for each stage: bring down one dividend bit, MSB first
  always_comb begin
    for (int k = 0; k <= NS; k++) begin
      for (int a = 0; a < NA; a++) begin
        trial[k][a] = '0;
        qbit[k][a]  = 1'b0;
        rnext[k][a] = '0;
      end
    end
    for (int k = 1; k <= NS; k++) begin
      for (int a = 0; a < NA; a++) begin
        trial[k][a] = {rem_r[k-1][a], dvd_r[k-1][a][NS-k]};
        qbit[k][a]  = (trial[k][a] >= {1'b0, cs_r[k-1]});
        rnext[k][a] = qbit[k][a] ? W'(trial[k][a] - {1'b0, cs_r[k-1]}) : trial[k][a][W-1:0];
      end
    end
  end

  // Stage 0 folds the sign: floor(x/c) for x<0 is -(~x / c) - 1, odd flip in parity
  always_ff @(posedge clk) begin
    if (en) begin
      cs_r[0]   <= (cell_sz == '0) ? W'(1) : cell_sz;
      flip_r[0] <= px[tcs_pkg::COORD_W-1] ^ py[tcs_pkg::COORD_W-1] ^ pz[tcs_pkg::COORD_W-1];
      for (int a = 0; a < NA; a++) begin
        dvd_r[0][a] <= pin[a][tcs_pkg::COORD_W-1] ? ~pin[a][W-1:0] : pin[a][W-1:0];
        rem_r[0][a] <= '0;
      end
      for (int k = 1; k < NS; k++) begin
        cs_r[k]   <= cs_r[k-1];
        flip_r[k] <= flip_r[k-1];
        for (int a = 0; a < NA; a++) begin
          dvd_r[k][a] <= dvd_r[k-1][a];
          rem_r[k][a] <= rnext[k][a];
        end
      end
      for (int a = 0; a < NA; a++) begin
        qlsb_r[a] <= qbit[NS][a];
      end
      flip_last_r <= flip_r[NS-1];
    end
  end

  assign parity = flip_last_r ^ qlsb_r[0] ^ qlsb_r[1] ^ qlsb_r[2];

endmodule

[hdl/tcs_plane_idx.sv]
// Planar map: plane dot products, scaling and wrap into an image store access.
module tcs_plane_idx #(
  parameter int TEX_WIDTH  = 256,
  parameter int TEX_HEIGHT = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  tcs_pkg::plane_cfg_t                cfg,
  input  logic signed [tcs_pkg::COORD_W-1:0] px,
  input  logic signed [tcs_pkg::COORD_W-1:0] py,
  input  logic signed [tcs_pkg::COORD_W-1:0] pz,
  input  logic                               wr,
  input  logic [7:0]                         row,
  input  logic [7:0]                         col,
  input  logic [tcs_pkg::COLOR_W-1:0]        color,
  output tcs_pkg::mem_req_t                  req
);

  localparam int MAXSZ = (TEX_WIDTH > TEX_HEIGHT) ? TEX_WIDTH : TEX_HEIGHT;
  localparam int SW    = $clog2(MAXSZ + 1);
  localparam int IW    = (SW > 8) ? SW : 8;
  localparam int NWQ   = tcs_pkg::MEM_STAGE - 1;

  // Plane 0 is s (column), plane 1 is r (row)
  logic signed [31:0] cx [2];
  logic signed [31:0] cy [2];
  logic signed [31:0] cz [2];
  logic signed [31:0] co [2];
  logic [SW-1:0]      size [2];

  assign cx[0] = cfg.s_xy[63:32];
  assign cy[0] = cfg.s_xy[31:0];
  assign cz[0] = cfg.s_zw[63:32];
  assign co[0] = cfg.s_zw[31:0];
  assign cx[1] = cfg.r_xy[63:32];
  assign cy[1] = cfg.r_xy[31:0];
  assign cz[1] = cfg.r_zw[63:32];
  assign co[1] = cfg.r_zw[31:0];
  assign size[0] = SW'(TEX_WIDTH);
  assign size[1] = SW'(TEX_HEIGHT);

  logic signed [63:0] prx_r [2];
  logic signed [63:0] pry_r [2];
  logic signed [63:0] prz_r [2];
  logic signed [47:0] off_r [2];
  logic signed [65:0] sum_r [2];
  logic               neg_r [2];
  logic [31:0]        frac_r[2];
  tcs_pkg::mem_req_t  wq_r  [NWQ];
  tcs_pkg::mem_req_t  req_r;

  logic [31+SW:0] scaled [2];
  logic [SW-1:0]  q      [2];
  logic [SW-1:0]  idx    [2];
  logic [IW-1:0]  idx_ext[2];

  // Scale the fraction by the image size, wrap negatives into [0, size)
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      scaled[p]  = {{SW{1'b0}}, frac_r[p]} * {32'h0, size[p]};
      q[p]       = scaled[p][31+SW:32];
      idx[p]     = (neg_r[p] && (q[p] != '0)) ? SW'(size[p] - q[p]) : q[p];
      idx_ext[p] = IW'(idx[p]);
    end
  end

  // Products, sum, fraction, then the store access
  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        prx_r[p]  <= cx[p] * px;
        pry_r[p]  <= cy[p] * py;
        prz_r[p]  <= cz[p] * pz;
        off_r[p]  <= $signed({co[p], 16'h0});
        sum_r[p]  <= 66'(prx_r[p]) + 66'(pry_r[p]) + 66'(prz_r[p]) + 66'(off_r[p]);
        neg_r[p]  <= sum_r[p][65];
        frac_r[p] <= sum_r[p][65] ? 32'(32'h0 - sum_r[p][31:0]) : sum_r[p][31:0];
      end
      wq_r[0].addr <= {row, col};
      wq_r[0].data <= color;
      for (int k = 1; k < NWQ; k++) begin
        wq_r[k].addr <= wq_r[k-1].addr;
        wq_r[k].data <= wq_r[k-1].data;
      end
      req_r.addr <= wq_r[NWQ-1].we ? wq_r[NWQ-1].addr : {idx_ext[1][7:0], idx_ext[0][7:0]};
      req_r.data <= wq_r[NWQ-1].data;
    end
    // Write strobes are control state
    if (!rst_n) begin
      for (int k = 0; k < NWQ; k++) wq_r[k].we <= 1'b0;
      req_r.we <= 1'b0;
    end else if (en) begin
      wq_r[0].we <= wr;
      for (int k = 1; k < NWQ; k++) wq_r[k].we <= wq_r[k-1].we;
      req_r.we <= wq_r[NWQ-1].we;
    end
  end

  assign req = req_r;

endmodule

[hdl/tcs_image_mem.sv]
// Image store: single-port synchronous RAM, one access per advancing cycle.
module tcs_image_mem (
  input  logic                        clk,
  input  logic                        en,
  input  tcs_pkg::mem_req_t           req,
  output logic [tcs_pkg::COLOR_W-1:0] rdata
);

  logic [tcs_pkg::COLOR_W-1:0] mem [tcs_pkg::STORE_DEPTH];
  logic [tcs_pkg::COLOR_W-1:0] rdata_r;

  // Writes and reads follow pipeline order, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (en) begin
      if (req.we) begin
        mem[req.addr] <= req.data;
      end
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/texture_color_sampler.sv]
// Texture color sampler top level: config registers, pipeline control, color select.
//
// in_ch carries sample transactions (opcode sample, point_x/y/z in signed Q16.16)
// and texel write transactions (opcode write, texel_row/col/color). out_ch returns
// one sampled_color per sample transaction, in order; writes return nothing.
// cfg_we/cfg_index/cfg_wdata write the mode, checker cell size, the two colors
// and the four plane coefficient registers; write them only while idle.
// The pipeline depth is set by the checker divider, which retires one quotient
// bit per stage over 31 stages. The planar path (multiply, sum, scale, store
// read) finishes earlier and is delayed to match. Throughput is one transaction
// per cycle while out_ch is not stalled; the image store has one port and takes
// one read or write per advancing cycle at a fixed pipeline position.
// The whole pipeline advances together: when out_ch holds a result that is not
// taken, in_ch.ready drops and every stage holds. Reset clears the pipeline
// valids and loads the register defaults; the image store is not cleared and
// must be written before a texel is sampled.
module texture_color_sampler #(
  parameter int TEX_WIDTH  = 256,
  parameter int TEX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tcs_in_if.sink                        in_ch,
  tcs_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcs_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int NV = tcs_pkg::DIV_LAST + 1;

  tcs_pkg::mode_t              mode_r;
  logic [tcs_pkg::CELL_W-1:0]  cell_r;
  logic [tcs_pkg::COLOR_W-1:0] color_a_r;
  logic [tcs_pkg::COLOR_W-1:0] color_b_r;
  tcs_pkg::plane_cfg_t         plane_r;

  logic                        adv;
  logic [NV-1:0]               vld_r;
  logic [NV-1:0]               op_r;
  logic                        out_valid_r;
  logic [tcs_pkg::COLOR_W-1:0] out_color_r;
  logic [tcs_pkg::COLOR_W-1:0] color_nxt;
  logic [tcs_pkg::COLOR_W-1:0] tex_dly_r [tcs_pkg::TEX_DLY];

  logic                        parity;
  tcs_pkg::mem_req_t           req;
  logic [tcs_pkg::COLOR_W-1:0] rdata;

  // Whole pipeline moves when the output register is free or being taken
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.sampled_color = out_color_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tcs_pkg::MODE_SOLID;
      cell_r    <= tcs_pkg::CELL_W'(65536);
      color_a_r <= '0;
      color_b_r <= '1;
      plane_r   <= '0;
    end else if (cfg_we) begin
      unique case (tcs_pkg::cfg_idx_t'(cfg_index))
        tcs_pkg::CFG_MODE:       mode_r    <= tcs_pkg::mode_t'(cfg_wdata[1:0]);
        tcs_pkg::CFG_CELL_SIZE:  cell_r    <= cfg_wdata[tcs_pkg::CELL_W-1:0];
        tcs_pkg::CFG_COLOR_A:    color_a_r <= cfg_wdata[tcs_pkg::COLOR_W-1:0];
        tcs_pkg::CFG_COLOR_B:    color_b_r <= cfg_wdata[tcs_pkg::COLOR_W-1:0];
        tcs_pkg::CFG_PLANE_S_XY: plane_r.s_xy <= cfg_wdata;
        tcs_pkg::CFG_PLANE_S_ZW: plane_r.s_zw <= cfg_wdata;
        tcs_pkg::CFG_PLANE_R_XY: plane_r.r_xy <= cfg_wdata;
        tcs_pkg::CFG_PLANE_R_ZW: plane_r.r_zw <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcs_chk_div u_div (
    .clk     (clk),
    .en      (adv),
    .px      (in_ch.point_x),
    .py      (in_ch.point_y),
    .pz      (in_ch.point_z),
    .cell_sz (cell_r),
    .parity  (parity)
  );

  tcs_plane_idx #(
    .TEX_WIDTH  (TEX_WIDTH),
    .TEX_HEIGHT (TEX_HEIGHT)
  ) u_plane (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .cfg   (plane_r),
    .px    (in_ch.point_x),
    .py    (in_ch.point_y),
    .pz    (in_ch.point_z),
    .wr    (in_ch.valid && (in_ch.opcode == tcs_pkg::OP_WRITE)),
    .row   (in_ch.texel_row),
    .col   (in_ch.texel_col),
    .color (in_ch.texel_color),
    .req   (req)
  );

  tcs_image_mem u_mem (
    .clk   (clk),
    .en    (adv),
    .req   (req),
    .rdata (rdata)
  );

  // Texel delay to line up with the divider result
  always_ff @(posedge clk) begin
    if (adv) begin
      tex_dly_r[0] <= rdata;
      for (int k = 1; k < tcs_pkg::TEX_DLY; k++) tex_dly_r[k] <= tex_dly_r[k-1];
    end
  end

  // Transaction valid and opcode pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      op_r  <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_ch.valid};
      op_r  <= {op_r[NV-2:0], in_ch.opcode};
    end
  end

  // Final color select
  always_comb begin
    case (mode_r)
      tcs_pkg::MODE_CHECKER: color_nxt = parity ? color_b_r : color_a_r;
      tcs_pkg::MODE_PLANAR:  color_nxt = tex_dly_r[tcs_pkg::TEX_DLY-1];
      default:               color_nxt = color_a_r;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NV-1] && (op_r[NV-1] == tcs_pkg::OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_color_r <= color_nxt;
    end
  end

  // A texel write reaching the end never becomes a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[NV-1] && (op_r[NV-1] == tcs_pkg::OP_WRITE)) |=> !out_valid_r)
    else $error("write transaction produced a result");

  // A stalled pipeline keeps every in-flight transaction
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  // Store writes only come from accepted write transactions
  a_store_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && req.we) |-> (vld_r[tcs_pkg::MEM_STAGE-1] && op_r[tcs_pkg::MEM_STAGE-1]))
    else $error("image store write without a write transaction");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
